/* src/rmq_pkg.sv */
// Shared constants and types for the rotation matrix to quaternion block.
package rmq_pkg;

    localparam int ELEM_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int DIV_STEP = 4;
    localparam int SQ_STEP  = 2;

    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2,
        COMP_W = 2'd3
    } comp_t;

endpackage

/* src/rmq_mat_if.sv */
// Matrix input channel: valid, ready and nine signed elements.
interface rmq_mat_if
    import rmq_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] elem_xx;
    logic signed [ELEM_WIDTH-1:0] elem_xy;
    logic signed [ELEM_WIDTH-1:0] elem_xz;
    logic signed [ELEM_WIDTH-1:0] elem_yx;
    logic signed [ELEM_WIDTH-1:0] elem_yy;
    logic signed [ELEM_WIDTH-1:0] elem_yz;
    logic signed [ELEM_WIDTH-1:0] elem_zx;
    logic signed [ELEM_WIDTH-1:0] elem_zy;
    logic signed [ELEM_WIDTH-1:0] elem_zz;

    modport source (
        output valid, elem_xx, elem_xy, elem_xz, elem_yx, elem_yy, elem_yz,
               elem_zx, elem_zy, elem_zz,
        input  ready
    );
    modport sink (
        input  valid, elem_xx, elem_xy, elem_xz, elem_yx, elem_yy, elem_yz,
               elem_zx, elem_zy, elem_zz,
        output ready
    );
endinterface

/* src/rmq_quat_if.sv */
// Quaternion output channel: valid, ready, four components and the flag.
interface rmq_quat_if
    import rmq_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] quat_x;
    logic signed [ELEM_WIDTH-1:0] quat_y;
    logic signed [ELEM_WIDTH-1:0] quat_z;
    logic signed [ELEM_WIDTH-1:0] quat_w;
    logic                         not_rotation;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, not_rotation,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, not_rotation,
        output ready
    );
endinterface

/* src/rmq_cfg_if.sv */
// Configuration write channel carrying the row convention bit.
interface rmq_cfg_if;
    logic valid;
    logic ready;
    logic row_convention;

    modport source (
        output valid, row_convention,
        input  ready
    );
    modport sink (
        input  valid, row_convention,
        output ready
    );
endinterface

/* src/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion, pipelined Shepperd conversion.
// Default format is 16-bit Q2.14. The stages are those of the restoring divider
// (4 quotient bits per stage) and the square root (2 root bits per stage) that
// form 0.5/sqrt(qt), plus a select, a scale and an output stage.
// Throughput: one item per cycle; a full stage stalls while the next one does.
// Reset: valid bits clear and row_convention returns to 0 asynchronously.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    rmq_cfg_if.sink    cfg,
    rmq_mat_if.sink    mat,
    rmq_quat_if.source quat
);

    localparam int EW      = ELEM_WIDTH;
    localparam int QS_FRAC = (62 - FRAC_BITS) / 2;
    localparam int NUM_EXP = 2 * QS_FRAC + FRAC_BITS;
    localparam int QUO_W   = NUM_EXP + 1;
    localparam int TW      = ((FRAC_BITS + 1 > EW) ? FRAC_BITS + 1 : EW) + 3;
    localparam int MW      = TW - 1;
    localparam int SQ_W    = (QUO_W + 1) / 2;
    localparam int PW      = MW + SQ_W;
    localparam int DS      = (QUO_W + DIV_STEP - 1) / DIV_STEP;
    localparam int SS      = (SQ_W + SQ_STEP - 1) / SQ_STEP;
    localparam int PP      = DS + SS + 1;
    localparam int LAST    = DS + SS + 2;

    localparam logic signed [TW-1:0] ONE_FX   = TW'(64'sd1 <<< FRAC_BITS);
    localparam logic [PW:0]          RND_HALF = (PW+1)'(1) << (QS_FRAC - 1);
    localparam logic [PW:0]          LIM      = (PW+1)'(1) << (EW - 1);

    typedef struct packed {
        logic [1:0]           sel;
        logic                 nr;
        logic [3:0]           neg;
        logic [3:0][MW-1:0]   mag;
    } ctx_t;

    logic             row_conv_reg;
    logic [LAST:0]    v_reg;
    logic [LAST+1:0]  en;

    ctx_t             ctx_next;
    logic [MW-1:0]    t_next;
    ctx_t             ctx_reg    [0:LAST-1];
    logic [MW-1:0]    dv_t_reg   [0:DS];
    logic [MW-1:0]    dv_rem_reg [1:DS];
    logic [QUO_W-1:0] dv_quo_reg [1:DS];
    logic [SQ_W:0]    sq_rem_reg [1:SS];
    logic [SQ_W-1:0]  sq_root_reg[1:SS];
    logic [2*SQ_W-1:0] sq_q_reg  [1:SS];
    logic [PW-1:0]    prod_reg   [0:3];

    logic signed [EW-1:0] q_next [0:3];
    logic signed [EW-1:0] q_reg  [0:3];
    logic                 nr_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_conv_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            row_conv_reg <= cfg.row_convention;
        end
    end

    // Advance each stage when it is empty or the next one moves.
    always_comb
    begin
        en[LAST+1] = quat.ready;
        for (int p = LAST; p >= 0; p--)
        begin
            en[p] = !v_reg[p] || en[p+1];
        end
    end

    assign mat.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= mat.valid;
            end
            for (int p = 1; p <= LAST; p++)
            begin
                if (en[p])
                begin
                    v_reg[p] <= v_reg[p-1];
                end
            end
        end
    end

    // Case select, trace term and off-diagonal sums and differences.
    always_comb
    begin
        logic signed [TW-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz;
        logic signed [TW-1:0] qt, a1, b1, a2, b2, a3, b3;
        logic signed [TW-1:0] tv [0:3];
        logic [1:0]           c;
        logic                 n1, n2, n3;
        xx = TW'(mat.elem_xx);
        xy = TW'(mat.elem_xy);
        xz = TW'(mat.elem_xz);
        yx = TW'(mat.elem_yx);
        yy = TW'(mat.elem_yy);
        yz = TW'(mat.elem_yz);
        zx = TW'(mat.elem_zx);
        zy = TW'(mat.elem_zy);
        zz = TW'(mat.elem_zz);
        if (zz < 0)
        begin
            c = (xx > yy) ? COMP_X : COMP_Y;
        end
        else
        begin
            c = (xx + yy < 0) ? COMP_Z : COMP_W;
        end
        n1 = c[1];
        n2 = c[0];
        n3 = (c == COMP_X) || (c == COMP_W);
        qt = ONE_FX + (n3 ? xx : -xx) + (n2 ? yy : -yy) + (n1 ? zz : -zz);
        a1 = row_conv_reg ? xy : yx;
        b1 = row_conv_reg ? yx : xy;
        a2 = row_conv_reg ? zx : xz;
        b2 = row_conv_reg ? xz : zx;
        a3 = row_conv_reg ? yz : zy;
        b3 = row_conv_reg ? zy : yz;
        tv[0] = qt;
        tv[1] = a1 + (n1 ? -b1 : b1);
        tv[2] = a2 + (n2 ? -b2 : b2);
        tv[3] = a3 + (n3 ? -b3 : b3);
        ctx_next.sel = c;
        ctx_next.nr  = (qt <= 0);
        for (int k = 0; k < 4; k++)
        begin
            ctx_next.neg[k] = tv[k][TW-1];
            ctx_next.mag[k] = tv[k][TW-1] ? MW'(-tv[k]) : MW'(tv[k]);
        end
        t_next = (qt <= 0) ? MW'(1) : MW'(qt);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ctx_reg[0]  <= ctx_next;
            dv_t_reg[0] <= t_next;
        end
    end

    genvar gp;
    generate
        for (gp = 1; gp <= LAST - 1; gp++)
        begin : g_ctx
            always_ff @(posedge clk)
            begin
                if (en[gp])
                begin
                    ctx_reg[gp] <= ctx_reg[gp-1];
                end
            end
        end

        // Restoring division of the power of two by qt.
        for (gp = 1; gp <= DS; gp++)
        begin : g_div
            localparam int J0 = (gp - 1) * DIV_STEP;
            logic [MW-1:0]    rem_next;
            logic [QUO_W-1:0] quo_next;

            always_comb
            begin
                logic [MW:0] sh;
                logic        qb;
                if (gp == 1)
                begin
                    rem_next = '0;
                    quo_next = '0;
                end
                else
                begin
                    rem_next = dv_rem_reg[gp == 1 ? 1 : gp-1];
                    quo_next = dv_quo_reg[gp == 1 ? 1 : gp-1];
                end
                for (int k = 0; k < DIV_STEP; k++)
                begin
                    if (J0 + k < QUO_W)
                    begin
                        sh = {rem_next, 1'((J0 + k) == 0)};
                        qb = (sh >= {1'b0, dv_t_reg[gp-1]});
                        if (qb)
                        begin
                            sh = sh - {1'b0, dv_t_reg[gp-1]};
                        end
                        rem_next = sh[MW-1:0];
                        quo_next = {quo_next[QUO_W-2:0], qb};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[gp])
                begin
                    dv_t_reg[gp]   <= dv_t_reg[gp-1];
                    dv_rem_reg[gp] <= rem_next;
                    dv_quo_reg[gp] <= quo_next;
                end
            end
        end

        // Digit-by-digit integer square root of the quotient.
        for (gp = 1; gp <= SS; gp++)
        begin : g_sqrt
            localparam int J0 = (gp - 1) * SQ_STEP;
            logic [SQ_W:0]     rem_next;
            logic [SQ_W-1:0]   root_next;
            logic [2*SQ_W-1:0] q_shift;

            always_comb
            begin
                logic [SQ_W+2:0] sh;
                logic [SQ_W+2:0] trial;
                if (gp == 1)
                begin
                    rem_next  = '0;
                    root_next = '0;
                    q_shift   = (2*SQ_W)'(dv_quo_reg[DS]);
                end
                else
                begin
                    rem_next  = sq_rem_reg[gp == 1 ? 1 : gp-1];
                    root_next = sq_root_reg[gp == 1 ? 1 : gp-1];
                    q_shift   = sq_q_reg[gp == 1 ? 1 : gp-1];
                end
                for (int k = 0; k < SQ_STEP; k++)
                begin
                    if (J0 + k < SQ_W)
                    begin
                        sh    = {rem_next, q_shift[2*SQ_W-1 -: 2]};
                        trial = {1'b0, root_next, 2'b01};
                        if (sh >= trial)
                        begin
                            sh        = sh - trial;
                            root_next = {root_next[SQ_W-2:0], 1'b1};
                        end
                        else
                        begin
                            root_next = {root_next[SQ_W-2:0], 1'b0};
                        end
                        rem_next = sh[SQ_W:0];
                        q_shift  = q_shift << 2;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[DS+gp])
                begin
                    sq_rem_reg[gp]  <= rem_next;
                    sq_root_reg[gp] <= root_next;
                    sq_q_reg[gp]    <= q_shift;
                end
            end
        end
    endgenerate

    // Scale each term by 0.5/sqrt(qt).
    always_ff @(posedge clk)
    begin
        logic [SQ_W:0]   s_inc;
        logic [SQ_W-1:0] scale;
        s_inc = {1'b0, sq_root_reg[SS]} + (SQ_W+1)'(1);
        scale = s_inc[SQ_W:1];
        if (en[PP])
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= PW'(ctx_reg[PP-1].mag[k]) * PW'(scale);
            end
        end
    end

    // Round, saturate and place the components.
    always_comb
    begin
        logic [PW:0]   r;
        logic [PW:0]   rm;
        logic [1:0]    idx;
        ctx_t          cx;
        cx = ctx_reg[PP];
        for (int k = 0; k < 4; k++)
        begin
            q_next[k] = '0;
        end
        for (int k = 0; k < 4; k++)
        begin
            r   = ({1'b0, prod_reg[k]} + RND_HALF) >> QS_FRAC;
            idx = cx.sel ^ 2'(k);
            if (cx.neg[k])
            begin
                rm = (r > LIM) ? LIM : r;
                rm = (PW+1)'(0) - rm;
            end
            else
            begin
                rm = (r > LIM - 1'b1) ? LIM - 1'b1 : r;
            end
            if (!cx.nr)
            begin
                q_next[idx] = rm[EW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            for (int k = 0; k < 4; k++)
            begin
                q_reg[k] <= q_next[k];
            end
            nr_reg <= ctx_reg[PP].nr;
        end
    end

    assign quat.valid        = v_reg[LAST];
    assign quat.quat_x       = q_reg[COMP_X];
    assign quat.quat_y       = q_reg[COMP_Y];
    assign quat.quat_z       = q_reg[COMP_Z];
    assign quat.quat_w       = q_reg[COMP_W];
    assign quat.not_rotation = nr_reg;

endmodule

/* src/rmq_checker.sv */
// Port-level checks for the rotation matrix to quaternion block, with bind.
module rmq_port_checks #(
    parameter int EW = 16
)(
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [EW-1:0] quat_x,
    input logic [EW-1:0] quat_y,
    input logic [EW-1:0] quat_z,
    input logic [EW-1:0] quat_w,
    input logic          not_rotation
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable({quat_x, quat_y, quat_z, quat_w, not_rotation}))
        else $error("output item changed while stalled");

    a_nonrot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_rotation |->
            quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0)
        else $error("non-rotation item with nonzero components");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

endmodule

bind rotation_matrix_to_quaternion rmq_port_checks #(
    .EW (ELEM_WIDTH)
) u_rmq_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (mat.ready),
    .out_valid    (quat.valid),
    .out_ready    (quat.ready),
    .quat_x       (quat.quat_x),
    .quat_y       (quat.quat_y),
    .quat_z       (quat.quat_z),
    .quat_w       (quat.quat_w),
    .not_rotation (quat.not_rotation)
);

/* tb/rmq_checker.sv */
// Checker: predicts quaternions from accepted matrices and compares results.
module rmq_checker
    import rmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rmq_cfg_if.sink    cfg,
    rmq_mat_if.sink    mat,
    rmq_quat_if.sink   quat,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW = ELEM_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int QF = (62 - FB) / 2;
    localparam int QE = 2 * QF + FB - 2;

    typedef struct packed {
        logic signed [EW-1:0] qx;
        logic signed [EW-1:0] qy;
        logic signed [EW-1:0] qz;
        logic signed [EW-1:0] qw;
        logic                 nr;
    } quat_t;

    quat_t quat_expected[$];
    logic  row_conv;

    function automatic logic [63:0] scale_of(logic [63:0] t);
        logic [63:0] q, n, c, d;
        q = (64'd1 << (QE + 2)) / t;
        n = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = n | (64'd1 << b);
            d = 2 * c - 1;
            if (d <= q / d)
                n = c;
        end
        return n;
    endfunction

    function automatic logic signed [EW-1:0] scaled(longint s, logic [63:0] qs);
        logic [63:0] mag, r, lim;
        mag = (s < 0) ? 64'(-s) : 64'(s);
        r = (mag * qs + (64'd1 << (QF - 1))) >> QF;
        lim = 64'd1 << (EW - 1);
        if (s < 0)
        begin
            if (r > lim)
                r = lim;
            return EW'(-r);
        end
        if (r > lim - 1)
            r = lim - 1;
        return EW'(r);
    endfunction

    function automatic quat_t quat_of(logic rc, longint xx, longint xy, longint xz,
        longint yx, longint yy, longint yz, longint zx, longint zy, longint zz);
        logic [1:0] c;
        longint s1, s2, s3, qt;
        longint tk[4];
        logic signed [EW-1:0] comp[4];
        logic [63:0] qs;
        quat_t r;
        if (zz < 0)
            c = (xx > yy) ? COMP_X : COMP_Y;
        else
            c = (xx + yy < 0) ? COMP_Z : COMP_W;
        s1 = c[1] ? -1 : 1;
        s2 = c[0] ? -1 : 1;
        s3 = (c == COMP_X || c == COMP_W) ? -1 : 1;
        qt = (longint'(1) << FB) - s3 * xx - s2 * yy - s1 * zz;
        r = '0;
        if (qt <= 0)
        begin
            r.nr = 1'b1;
            return r;
        end
        tk[0] = qt;
        if (rc)
        begin
            tk[1] = xy + s1 * yx;
            tk[2] = zx + s2 * xz;
            tk[3] = yz + s3 * zy;
        end
        else
        begin
            tk[1] = yx + s1 * xy;
            tk[2] = xz + s2 * zx;
            tk[3] = zy + s3 * yz;
        end
        qs = scale_of(64'(qt));
        for (int k = 0; k < 4; k++)
            comp[c ^ 2'(k)] = scaled(tk[k], qs);
        r.qx = comp[COMP_X];
        r.qy = comp[COMP_Y];
        r.qz = comp[COMP_Z];
        r.qw = comp[COMP_W];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        quat_t e;
        if (!rst_n)
        begin
            row_conv <= 1'b0;
            fail_count <= 0;
            quat_expected.delete();
        end
        else
        begin
            if (mat.valid && mat.ready)
                quat_expected.push_back(quat_of(row_conv, mat.elem_xx, mat.elem_xy,
                    mat.elem_xz, mat.elem_yx, mat.elem_yy, mat.elem_yz,
                    mat.elem_zx, mat.elem_zy, mat.elem_zz));
            if (cfg.valid && cfg.ready)
                row_conv <= cfg.row_convention;
            if (quat.valid && quat.ready)
            begin
                if (quat_expected.size() == 0)
                begin
                    $error("unexpected quaternion item");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = quat_expected.pop_front();
                    if (quat.quat_x !== e.qx || quat.quat_y !== e.qy ||
                        quat.quat_z !== e.qz || quat.quat_w !== e.qw ||
                        quat.not_rotation !== e.nr)
                    begin
                        fail_count <= fail_count + 1;
                        if (quat.quat_x !== e.qx)
                            $error("quat_x expected %0d got %0d", e.qx, quat.quat_x);
                        if (quat.quat_y !== e.qy)
                            $error("quat_y expected %0d got %0d", e.qy, quat.quat_y);
                        if (quat.quat_z !== e.qz)
                            $error("quat_z expected %0d got %0d", e.qz, quat.quat_z);
                        if (quat.quat_w !== e.qw)
                            $error("quat_w expected %0d got %0d", e.qw, quat.quat_w);
                        if (quat.not_rotation !== e.nr)
                            $error("not_rotation expected %0b got %0b", e.nr,
                                quat.not_rotation);
                    end
                end
            end
        end
        pending = quat_expected.size();
    end
endmodule

/* tb/tb_rotation_matrix_to_quaternion.sv */
// Testbench top: drives matrices and configuration, gives the verdict.
module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW = ELEM_WIDTH_DEF;
    localparam int LATENCY = 40;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, pending, idle_cycles;
    logic quiet;
    logic signed [EW-1:0] m[9];

    rmq_cfg_if             cfg();
    rmq_mat_if  #(.ELEM_WIDTH(EW)) mat();
    rmq_quat_if #(.ELEM_WIDTH(EW)) quat();

    rotation_matrix_to_quaternion u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .mat  (mat),
        .quat (quat)
    );

    rmq_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .mat       (mat),
        .quat      (quat),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        cfg.valid = 1'b0;
        cfg.row_convention = 1'b0;
        mat.valid = 1'b0;
        {mat.elem_xx, mat.elem_xy, mat.elem_xz, mat.elem_yx, mat.elem_yy,
         mat.elem_yz, mat.elem_zx, mat.elem_zy, mat.elem_zz} = '0;
        quat.ready = 1'b0;
    end

    // output stall bursts
    always
    begin
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            quat.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        quat.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((mat.valid && mat.ready) || (quat.valid && quat.ready) ||
            (cfg.valid && cfg.ready) || (pending == 0 && !mat.valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_matrix();
        if (!quiet && $urandom_range(0, 6) == 0)
        begin
            mat.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        mat.valid <= 1'b1;
        mat.elem_xx <= m[0]; mat.elem_xy <= m[1]; mat.elem_xz <= m[2];
        mat.elem_yx <= m[3]; mat.elem_yy <= m[4]; mat.elem_yz <= m[5];
        mat.elem_zx <= m[6]; mat.elem_zy <= m[7]; mat.elem_zz <= m[8];
        do @(posedge clk); while (!mat.ready);
        @(negedge clk);
    endtask

    task automatic write_convention(logic v);
        mat.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.row_convention <= v;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // near-rotation: signed unit diagonal with small jitter, random off-diagonals in [-1, 1)
    task automatic make_rotation_like();
        int sel;
        sel = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++)
            m[i] = EW'($signed($urandom_range(0, 32767)) - 16384);
        case (sel)
            0: begin m[0] = 16384; m[4] = -16384; m[8] = -16384; end
            1: begin m[0] = -16384; m[4] = 16384; m[8] = -16384; end
            2: begin m[0] = -16384; m[4] = -16384; m[8] = 16384; end
            default: begin m[0] = 16384; m[4] = 16384; m[8] = 16384; end
        endcase
        for (int i = 0; i < 9; i += 4)
            m[i] = m[i] + EW'($signed($urandom_range(0, 8191)) - 4096);
    endtask

    initial
    begin
        quiet = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph > 0)
                write_convention(ph[0]);
            // directed extremes and each case
            for (int d = 0; d < 8; d++)
            begin
                for (int i = 0; i < 9; i++)
                    m[i] = 0;
                case (d)
                    0: begin m[0] = 16384; m[4] = 16384; m[8] = 16384; end
                    1: begin m[0] = 16384; m[4] = -16384; m[8] = -16384; end
                    2: begin m[0] = -16384; m[4] = 16384; m[8] = -16384; end
                    3: begin m[0] = -16384; m[4] = -16384; m[8] = 16384; end
                    4: for (int i = 0; i < 9; i++) m[i] = 16'sh8000;
                    5: for (int i = 0; i < 9; i++) m[i] = 16'sh7fff;
                    6: begin m[0] = 16'sh7fff; m[4] = 16'sh7fff; m[8] = -1; end
                    default: begin m[0] = 16'sh7fff; m[1] = 16'sh8000; m[3] = 16'sh7fff;
                        m[8] = 16'sh8000; end
                endcase
                send_matrix();
            end
            for (int n = 0; n < 380; n++)
            begin
                if (ph == 3 && n > 300)
                    quiet = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    for (int i = 0; i < 9; i++)
                        m[i] = EW'($urandom);
                else
                    make_rotation_like();
                send_matrix();
            end
        end
        mat.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
